[hw/rtl/sorted_list_engine_unit_defines.svh]
// Assertion macros used by the sorted list engine checker.
`ifndef SORTED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LIST_ENGINE_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define SLE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sorted list engine check failed");

// Property that must hold in the cycle after its trigger.
`define SLE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sorted list engine check failed");

`endif

[hw/rtl/sle_pkg.sv]
// Types, constants and helpers shared by the sorted list engine.
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_MAX    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] max_value;
    logic [4:0]         entry_count;
  } out_beat_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] key;
  } cell_ctrl_t;

  // Low five bits of an entry count, zero-extended when the count is narrower.
  function automatic logic [4:0] count5(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+4:0] ext;
    ext = {{5{1'b0}}, cnt};
    return ext[4:0];
  endfunction

endpackage

[hw/rtl/sle_cell.sv]
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module sle_cell (
  input  logic                clk,
  input  logic                occupied,
  input  sle_pkg::cell_ctrl_t ctrl,
  input  logic                left_lt,
  input  logic signed [31:0]  left_value,
  input  logic signed [31:0]  right_value,
  output logic                lt,
  output logic                eq,
  output logic signed [31:0]  value
);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  // Compare the stored entry against the broadcast key.
  assign lt    = occupied && (value_r < ctrl.key);
  assign eq    = occupied && (value_r == ctrl.key);
  assign value = value_r;

  // Cells at or past the insert point shift right; at or past the delete point, left.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins && !lt) begin
      value_nxt = left_lt ? ctrl.key : left_value;
    end else if (ctrl.del && !lt) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[hw/rtl/sorted_list_engine_unit.sv]
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending order in a row
// of cells. Every cell compares its entry with the operand in parallel and then shifts with
// its neighbors for each action (insert, delete, search, find maximum). An item is accepted
// every cycle unless stalled, and its result beat appears in the cycle after it is accepted.
// The output register holds a stalled result and input accepts pause only while
// that result is stalled. The compare and shift across the whole row of cells sets the
// clock path. No clearing pass is needed after reset; occupancy follows the entry count.
module sorted_list_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sle_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sle_pkg::out_beat_t  out_data
);

  localparam int N = sle_pkg::CAPACITY;

  logic [sle_pkg::CNT_W-1:0] count_r;
  logic [sle_pkg::CNT_W-1:0] count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  sle_pkg::out_beat_t        out_data_r;
  sle_pkg::out_beat_t        out_data_nxt;

  logic [N-1:0]              occ;
  logic [N-1:0]              lt;
  logic [N-1:0]              eq;
  logic signed [31:0]        cell_value [N];
  logic [N-1:0]              is_last;
  logic signed [31:0]        max_sel;
  sle_pkg::cell_ctrl_t       ctrl;

  logic accept;
  logic empty;
  logic full;
  logic found;

  assign accept = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign empty = (count_r == '0);
  assign full = (count_r == sle_pkg::CNT_W'(N));
  assign found = |eq;

  // Occupancy is a thermometer code of the entry count.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      occ[i] = (sle_pkg::CNT_W'(i) < count_r);
    end
    for (int i = 0; i < N - 1; i++) begin
      is_last[i] = occ[i] && !occ[i+1];
    end
    is_last[N-1] = occ[N-1];
  end

  // Shift command for the chain.
  always_comb begin
    ctrl.key = in_data.value;
    ctrl.ins = accept && (in_data.action == sle_pkg::ACT_INSERT) && !full;
    ctrl.del = accept && (in_data.action == sle_pkg::ACT_DELETE) && found;
  end

  // Row of cells, each wired to its neighbors; the head takes the input value, the tail its own.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic               l_lt;
    logic signed [31:0] l_val;
    logic signed [31:0] r_val;

    if (g == 0) begin : g_head
      assign l_lt  = 1'b1;
      assign l_val = in_data.value;
    end else begin : g_body
      assign l_lt  = lt[g-1];
      assign l_val = cell_value[g-1];
    end

    if (g == N - 1) begin : g_tail
      assign r_val = cell_value[g];
    end else begin : g_inner
      assign r_val = cell_value[g+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .occupied    (occ[g]),
      .ctrl        (ctrl),
      .left_lt     (l_lt),
      .left_value  (l_val),
      .right_value (r_val),
      .lt          (lt[g]),
      .eq          (eq[g]),
      .value       (cell_value[g])
    );
  end

  // The maximum is the last occupied cell.
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < N; i++) begin
      max_sel = max_sel | (is_last[i] ? cell_value[i] : 32'sd0);
    end
  end

  // Status, count update and result beat.
  always_comb begin
    count_nxt = count_r;
    out_data_nxt = out_data_r;
    out_data_nxt.max_value = '0;
    out_data_nxt.status = sle_pkg::ST_EMPTY;
    case (in_data.action)
      sle_pkg::ACT_INSERT: begin
        if (full) begin
          out_data_nxt.status = sle_pkg::ST_FULL;
        end else begin
          out_data_nxt.status = sle_pkg::ST_INSERTED;
          count_nxt = count_r + 1'b1;
        end
      end
      sle_pkg::ACT_DELETE: begin
        if (empty) begin
          out_data_nxt.status = sle_pkg::ST_EMPTY;
        end else if (found) begin
          out_data_nxt.status = sle_pkg::ST_DELETED;
          count_nxt = count_r - 1'b1;
        end else begin
          out_data_nxt.status = sle_pkg::ST_NOT_FOUND;
        end
      end
      sle_pkg::ACT_SEARCH: begin
        if (empty) begin
          out_data_nxt.status = sle_pkg::ST_EMPTY;
        end else if (found) begin
          out_data_nxt.status = sle_pkg::ST_FOUND;
        end else begin
          out_data_nxt.status = sle_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (!empty) begin
          out_data_nxt.status = sle_pkg::ST_FOUND;
          out_data_nxt.max_value = max_sel;
        end
      end
    endcase
    out_data_nxt.entry_count = sle_pkg::count5(count_nxt);
    if (!accept) begin
      count_nxt = count_r;
      out_data_nxt = out_data_r;
    end
  end

  // Result beat holds until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/sle_checker.sv]
// Port-level checks for the sorted list engine and their binding to the top level.
`include "sorted_list_engine_unit_defines.svh"

module sle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sle_pkg::out_beat_t out_data
);

  // A stalled result beat stays put.
  `SLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Every accepted beat yields a result beat in the next cycle.
  `SLE_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)

  // A full report carries the full count.
  `SLE_ASSERT_NOW(a_full_count, out_valid && (out_data.status == sle_pkg::ST_FULL),
    out_data.entry_count == sle_pkg::count5(sle_pkg::CNT_W'(sle_pkg::CAPACITY)))

  // An empty report carries a zero count and a zero maximum.
  `SLE_ASSERT_NOW(a_empty_zero, out_valid && (out_data.status == sle_pkg::ST_EMPTY),
    (out_data.entry_count == 5'd0) && (out_data.max_value == 32'sd0))

endmodule

bind sorted_list_engine_unit sle_checker u_sle_checker (.*);
